/* sv/irs_pkg.sv */
package irs_pkg;

   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 256;
   localparam int MAX_CHANNELS = 4;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int IDX_W  = 8;
   localparam int ADDR_W = ROW_W + COL_W + CH_W;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam int SIZE_W = 9;
   localparam int STEP_W = 24;
   localparam int PIX_W  = 8;
   localparam int FRAC_W = 8;

   // shared multiply-add: a (up to STEP_W) times b (9 bits) plus signed addend
   localparam int MAC_A_W = STEP_W;
   localparam int MAC_B_W = 9;
   localparam int ACC_W   = 35;
   localparam int Q_SHIFT = 16;
   localparam logic signed [ACC_W-1:0] HALF_Q16 = 35'sd32768;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_X_STEP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_Y_STEP      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTERP_MODE = 3'd4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   // clamped neighbor indices and blend fraction along one axis
   typedef struct packed {
      logic [IDX_W-1:0]  idx0;
      logic [IDX_W-1:0]  idx1;
      logic [FRAC_W-1:0] frac;
   } coord_type;

endpackage

/* sv/image_resize_sampler.sv */
// Image resize sampler.
// Request channel: an item is taken at a rising edge with start high and busy
// low. req_op selects a transaction: write stores req_sample at
// (req_col, req_row, req_channel); read returns one resampled sample for the
// destination position (req_col, req_row, req_channel).
// Writes finish at the accept edge and never raise busy, so they can be
// issued every cycle while busy is low. A read raises busy from the next
// cycle on; the result is shown on rsp_pixel_value with rsp_valid high for
// exactly one cycle, the first cycle with busy low again, and the receiver
// cannot stall it. Reads do not overlap: a new read is taken only once
// busy is low again.
// Cost is set by one multiply-add unit (two position maps, six blend steps)
// and by one single-port sample memory read once per neighbor.
// CSR channel: csr_ready is always high; write only while no read is in
// flight. Indexes 0..4 are src_width, src_height, x_step, y_step,
// interp_mode; other indexes are dropped.
// Reset (synchronous, active high) idles the sequencer and loads register
// defaults. The sample memory is not cleared: a sample must be written
// before any read that uses it.
module image_resize_sampler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [7:0]                    req_col,
   input  logic [7:0]                    req_row,
   input  logic [1:0]                    req_channel,
   input  logic [7:0]                    req_sample,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_pixel_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [irs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [23:0]                   csr_data
);

   localparam int AW = irs_pkg::ACC_W;
   localparam int IW = irs_pkg::IDX_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PX, ST_PY, ST_CY, ST_FETCH,
      ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_OUT
   } state_type;

   // configuration
   logic [irs_pkg::SIZE_W-1:0] src_width_ff, src_height_ff;
   logic [irs_pkg::STEP_W-1:0] x_step_ff, y_step_ff;
   logic                       interp_mode_ff;

   // sequencer
   state_type                          state_ff;
   logic [2:0]                         cnt_ff;
   logic                               rsp_valid_ff;
   logic [irs_pkg::PIX_W-1:0]          rsp_pixel_ff;
   logic [7:0]                         col_ff, row_ff;
   logic [irs_pkg::CH_W-1:0]           ch_ff;
   irs_pkg::coord_type                 cx_ff, cy_ff;
   logic [irs_pkg::PIX_W-1:0]          smp_ff [4];
   logic [15:0]                        top_ff, bot_ff;

   // sample memory
   logic [irs_pkg::PIX_W-1:0]          mem [irs_pkg::DEPTH];
   logic [irs_pkg::PIX_W-1:0]          mem_q_ff;
   logic [irs_pkg::ADDR_W-1:0]         mem_addr;
   logic                               mem_we;

   logic                               accept;
   logic [IW-1:0]                      w_m1, h_m1, coord_m1;
   logic [2:0]                         fetch_n;
   logic [IW-1:0]                      fx_idx, fy_idx;

   logic                               mac_en;
   logic [irs_pkg::MAC_A_W-1:0]        mac_a;
   logic [irs_pkg::MAC_B_W-1:0]        mac_b;
   logic signed [AW-1:0]               mac_c, acc;
   logic signed [AW-1:0]               rounded;
   irs_pkg::coord_type                 coord;

   logic [irs_pkg::MAC_B_W-1:0]        wx_lo, wx_hi, wy_lo, wy_hi;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_ff;

   // effective size minus one: zero acts as one, above the store acts as max
   function automatic logic [IW-1:0] size_m1(
      input logic [irs_pkg::SIZE_W-1:0] s,
      input int                         maxv
   );
      if (s == '0) begin
         return '0;
      end else if (s > irs_pkg::SIZE_W'(maxv)) begin
         return IW'(maxv - 1);
      end else begin
         return IW'(s - 1'b1);
      end
   endfunction

   always_comb begin
      w_m1     = size_m1(src_width_ff, irs_pkg::MAX_WIDTH);
      h_m1     = size_m1(src_height_ff, irs_pkg::MAX_HEIGHT);
      coord_m1 = (state_ff == ST_PY) ? w_m1 : h_m1;
      fetch_n  = (interp_mode_ff == irs_pkg::MODE_BILINEAR) ? 3'd4 : 3'd1;
      // neighbor order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
      fx_idx   = cnt_ff[0] ? cx_ff.idx1 : cx_ff.idx0;
      fy_idx   = cnt_ff[1] ? cy_ff.idx1 : cy_ff.idx0;
      mem_we   = accept && (req_op == irs_pkg::OP_WRITE);
      if (state_ff == ST_FETCH) begin
         mem_addr = {fy_idx[irs_pkg::ROW_W-1:0], fx_idx[irs_pkg::COL_W-1:0], ch_ff};
      end else begin
         mem_addr = {req_row[irs_pkg::ROW_W-1:0], req_col[irs_pkg::COL_W-1:0],
                     req_channel[irs_pkg::CH_W-1:0]};
      end
      wx_hi = {1'b0, cx_ff.frac};
      wx_lo = 9'd256 - wx_hi;
      wy_hi = {1'b0, cy_ff.frac};
      wy_lo = 9'd256 - wy_hi;
      rounded = acc + irs_pkg::HALF_Q16;
   end

   // shared multiply-add operand select
   always_comb begin
      mac_en = 1'b1;
      mac_a  = '0;
      mac_b  = '0;
      mac_c  = '0;
      unique case (state_ff)
         ST_PX: begin
            mac_a = x_step_ff;
            mac_b = {1'b0, col_ff};
            mac_c = $signed({{(AW-irs_pkg::STEP_W+1){1'b0}},
                             x_step_ff[irs_pkg::STEP_W-1:1]}) - irs_pkg::HALF_Q16;
         end
         ST_PY: begin
            mac_a = y_step_ff;
            mac_b = {1'b0, row_ff};
            mac_c = $signed({{(AW-irs_pkg::STEP_W+1){1'b0}},
                             y_step_ff[irs_pkg::STEP_W-1:1]}) - irs_pkg::HALF_Q16;
         end
         ST_B0: begin
            mac_a = {{(irs_pkg::MAC_A_W-irs_pkg::PIX_W){1'b0}}, smp_ff[0]};
            mac_b = wx_lo;
         end
         ST_B1: begin
            mac_a = {{(irs_pkg::MAC_A_W-irs_pkg::PIX_W){1'b0}}, smp_ff[1]};
            mac_b = wx_hi;
            mac_c = acc;
         end
         ST_B2: begin
            mac_a = {{(irs_pkg::MAC_A_W-irs_pkg::PIX_W){1'b0}}, smp_ff[2]};
            mac_b = wx_lo;
         end
         ST_B3: begin
            mac_a = {{(irs_pkg::MAC_A_W-irs_pkg::PIX_W){1'b0}}, smp_ff[3]};
            mac_b = wx_hi;
            mac_c = acc;
         end
         ST_B4: begin
            mac_a = {{(irs_pkg::MAC_A_W-16){1'b0}}, top_ff};
            mac_b = wy_lo;
         end
         ST_B5: begin
            mac_a = {{(irs_pkg::MAC_A_W-16){1'b0}}, bot_ff};
            mac_b = wy_hi;
            mac_c = acc;
         end
         default: begin
            mac_en = 1'b0;
         end
      endcase
   end

   irs_mac u_mac (
      .clock (clock),
      .en    (mac_en),
      .a     (mac_a),
      .b     (mac_b),
      .c     (mac_c),
      .acc   (acc)
   );

   irs_coord u_coord (
      .pos     (acc),
      .size_m1 (coord_m1),
      .mode    (interp_mode_ff),
      .coord   (coord)
   );

   // sample memory: one port, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_sample;
      end
      mem_q_ff <= mem[mem_addr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= 9'd256;
         src_height_ff  <= 9'd256;
         x_step_ff      <= 24'd65536;
         y_step_ff      <= 24'd65536;
         interp_mode_ff <= irs_pkg::MODE_BILINEAR;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            irs_pkg::REG_SRC_WIDTH:   src_width_ff   <= csr_data[irs_pkg::SIZE_W-1:0];
            irs_pkg::REG_SRC_HEIGHT:  src_height_ff  <= csr_data[irs_pkg::SIZE_W-1:0];
            irs_pkg::REG_X_STEP:      x_step_ff      <= csr_data;
            irs_pkg::REG_Y_STEP:      y_step_ff      <= csr_data;
            irs_pkg::REG_INTERP_MODE: interp_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_op == irs_pkg::OP_READ) begin
                  col_ff   <= req_col;
                  row_ff   <= req_row;
                  ch_ff    <= req_channel[irs_pkg::CH_W-1:0];
                  state_ff <= ST_PX;
               end
            end
            ST_PX: begin
               state_ff <= ST_PY;
            end
            ST_PY: begin
               cx_ff    <= coord;
               state_ff <= ST_CY;
            end
            ST_CY: begin
               cy_ff    <= coord;
               cnt_ff   <= '0;
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               // address k goes out while sample k-1 comes back
               if (cnt_ff != '0) begin
                  smp_ff[2'(cnt_ff - 3'd1)] <= mem_q_ff;
               end
               if (cnt_ff == fetch_n) begin
                  state_ff <= (interp_mode_ff == irs_pkg::MODE_BILINEAR) ? ST_B0 : ST_OUT;
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            ST_B0: state_ff <= ST_B1;
            ST_B1: state_ff <= ST_B2;
            ST_B2: begin
               top_ff   <= acc[15:0];
               state_ff <= ST_B3;
            end
            ST_B3: state_ff <= ST_B4;
            ST_B4: begin
               bot_ff   <= acc[15:0];
               state_ff <= ST_B5;
            end
            ST_B5: state_ff <= ST_OUT;
            ST_OUT: begin
               rsp_valid_ff <= 1'b1;
               // blend sum is Q16: the integer sample sits right above the fraction
               if (interp_mode_ff == irs_pkg::MODE_BILINEAR) begin
                  rsp_pixel_ff <= rounded[irs_pkg::Q_SHIFT+irs_pkg::PIX_W-1:irs_pkg::Q_SHIFT];
               end else begin
                  rsp_pixel_ff <= smp_ff[0];
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* sv/irs_mac.sv */
module irs_mac (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [irs_pkg::MAC_A_W-1:0]          a,
   input  logic [irs_pkg::MAC_B_W-1:0]          b,
   input  logic signed [irs_pkg::ACC_W-1:0]     c,
   output logic signed [irs_pkg::ACC_W-1:0]     acc
);

   localparam int PROD_W = irs_pkg::MAC_A_W + irs_pkg::MAC_B_W;

   logic [PROD_W-1:0]                 prod;
   logic signed [irs_pkg::ACC_W-1:0]  acc_ff, acc_in;

   always_comb begin
      prod   = a * b;
      acc_in = $signed({{(irs_pkg::ACC_W-PROD_W){1'b0}}, prod}) + c;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* sv/irs_coord.sv */
module irs_coord (
   input  logic signed [irs_pkg::ACC_W-1:0] pos,
   input  logic [irs_pkg::IDX_W-1:0]        size_m1,
   input  logic                             mode,
   output irs_pkg::coord_type               coord
);

   localparam int AW = irs_pkg::ACC_W;

   function automatic logic [irs_pkg::IDX_W-1:0] clamp_idx(
      input logic signed [AW-1:0]        i,
      input logic [irs_pkg::IDX_W-1:0]   m1
   );
      logic signed [AW-1:0] lim;
      lim = $signed({{(AW-irs_pkg::IDX_W){1'b0}}, m1});
      if (i < 0) begin
         return '0;
      end else if (i > lim) begin
         return m1;
      end else begin
         return i[irs_pkg::IDX_W-1:0];
      end
   endfunction

   logic signed [AW-1:0] fl, fl_p1, rnd;

   always_comb begin
      fl    = pos >>> irs_pkg::Q_SHIFT;
      fl_p1 = fl + 35'sd1;
      // half away from zero: any negative position clamps to zero anyway
      rnd   = (pos + irs_pkg::HALF_Q16) >>> irs_pkg::Q_SHIFT;
      if (mode == irs_pkg::MODE_NEAREST) begin
         coord.idx0 = (pos < 0) ? '0 : clamp_idx(rnd, size_m1);
      end else begin
         coord.idx0 = clamp_idx(fl, size_m1);
      end
      coord.idx1 = clamp_idx(fl_p1, size_m1);
      coord.frac = pos[irs_pkg::Q_SHIFT-1 -: irs_pkg::FRAC_W];
   end

endmodule
